>>> rtl/uup_pkg.sv
// uup_pkg: shared types, character constants and position checks for the
// uuid text parser. No dependencies; used by uup_char_class, uup_out_stage and the top level.
package uup_pkg;

    localparam int unsigned CNT_W = 6;

    localparam logic [CNT_W-1:0] LEN_PLAIN  = 6'd32;
    localparam logic [CNT_W-1:0] LEN_HYPHEN = 6'd36;
    localparam logic [CNT_W-1:0] LEN_CURLY  = 6'd38;
    localparam logic [CNT_W-1:0] LEN_URN    = 6'd45;
    localparam logic [CNT_W-1:0] PREFIX_LEN = 6'd9;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 6'd63;

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

    // flag bit positions
    localparam int unsigned FLAG_PLAIN  = 0;
    localparam int unsigned FLAG_HYPHEN = 1;
    localparam int unsigned FLAG_CURLY  = 2;
    localparam int unsigned FLAG_URN    = 3;

    typedef enum logic [1:0] {
        LAYOUT_PLAIN  = 2'd0,
        LAYOUT_HYPHEN = 2'd1,
        LAYOUT_CURLY  = 2'd2,
        LAYOUT_URN    = 2'd3
    } uup_layout_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nib;
        logic [3:0] flag_keep;
    } uup_class_t;

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  layout;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
    } uup_result_t;

    // "urn:uuid:" by position
    function automatic logic [7:0] urn_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = 8'h75;
            4'd1:    ch = 8'h72;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h3A;
            4'd4:    ch = 8'h75;
            4'd5:    ch = 8'h75;
            4'd6:    ch = 8'h69;
            4'd7:    ch = 8'h64;
            4'd8:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // position check within the 8-4-4-4-12 hyphenated form
    function automatic logic hyphen_pos_ok(input logic [CNT_W-1:0] p,
                                           input logic [7:0] c,
                                           input logic is_hex);
        logic ok;
        if (p == 6'd8 || p == 6'd13 || p == 6'd18 || p == 6'd23)
        begin
            ok = (c == CH_HYPHEN);
        end
        else
        begin
            ok = is_hex;
        end
        return ok;
    endfunction

endpackage

>>> rtl/uup_char_class.sv
// uup_char_class: decodes one character at its string position into a hex
// nibble and the per-layout flags it leaves standing. Depends on uup_pkg.
module uup_char_class
(
    input  logic [7:0]               char_code,
    input  logic [uup_pkg::CNT_W-1:0] pos,
    output uup_pkg::uup_class_t      cls
);
    import uup_pkg::*;

    logic             is_digit;
    logic             is_lo;
    logic             is_up;
    logic             is_hex;
    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] pos_m9;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_lo    = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
    assign is_up    = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
    assign is_hex   = is_digit || is_lo || is_up;
    assign pos_m1   = pos - 6'd1;
    assign pos_m9   = pos - PREFIX_LEN;

    always_comb
    begin
        cls.is_hex    = is_hex;
        cls.nib       = is_digit ? char_code[3:0] : 4'(char_code[3:0] + HEX_ALPHA_OFS);
        cls.flag_keep = 4'hF;

        if (pos < LEN_PLAIN && !is_hex)
        begin
            cls.flag_keep[FLAG_PLAIN] = 1'b0;
        end

        if (pos < LEN_HYPHEN && !hyphen_pos_ok(pos, char_code, is_hex))
        begin
            cls.flag_keep[FLAG_HYPHEN] = 1'b0;
        end

        // braces: opening brace, hyphenated body shifted by one, closing brace
        if (pos == 6'd0)
        begin
            cls.flag_keep[FLAG_CURLY] = (char_code == CH_LBRACE);
        end
        else if (pos <= LEN_HYPHEN)
        begin
            cls.flag_keep[FLAG_CURLY] = hyphen_pos_ok(pos_m1, char_code, is_hex);
        end
        else if (pos == LEN_CURLY - 6'd1)
        begin
            cls.flag_keep[FLAG_CURLY] = (char_code == CH_RBRACE);
        end

        if (pos < PREFIX_LEN)
        begin
            cls.flag_keep[FLAG_URN] = (char_code == urn_char(pos[3:0]));
        end
        else if (pos < LEN_URN)
        begin
            cls.flag_keep[FLAG_URN] = hyphen_pos_ok(pos_m9, char_code, is_hex);
        end
    end

endmodule

>>> rtl/uup_out_stage.sv
// uup_out_stage: result register with valid/ready toward the consumer; it
// frees the input side when it is empty or the held word is taken. Depends on uup_pkg.
module uup_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  uup_pkg::uup_result_t  res_in,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output uup_pkg::uup_result_t  res_out
);
    import uup_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    uup_result_t res_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

>>> rtl/uuid_text_parser_core.sv
// uuid_text_parser_core: top level of the uuid text parser.
// Depends on uup_pkg, uup_char_class and uup_out_stage.
//
// Takes one character per cycle (valid/ready), the final one marked by
// last_char, and gives one result word per string: valid_res, layout (plain
// 32, hyphenated 36, braces 38, urn:uuid: 45 characters) and the 128-bit
// value as uuid_high/uuid_low, all zero when the text does not parse. Each
// character is classified and folded into the count, nibble shift register
// and layout flags in the cycle it is accepted; the result register loads on
// the final character and shows the result in the next cycle. Input is taken
// every cycle unless a result sits in the output register and out_ready is
// low. Parser state returns to reset after every final character.
module uuid_text_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [1:0]  layout,
    output logic [63:0] uuid_high,
    output logic [63:0] uuid_low
);
    import uup_pkg::*;

    logic             accept;
    logic             free;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [127:0]     acc_reg;
    logic [127:0]     acc_next;
    logic [3:0]       flags_reg;
    logic [3:0]       flags_next;
    logic [CNT_W-1:0] len;
    logic [3:0]       flags_upd;
    logic [127:0]     acc_upd;
    logic             ok;
    uup_layout_t      lay;
    uup_class_t       cls;
    uup_result_t      res;
    uup_result_t      res_q;

    assign in_ready = free;
    assign accept   = in_valid && free;

    uup_char_class u_class
    (
        .char_code (char_code),
        .pos       (count_reg),
        .cls       (cls)
    );

    assign len       = (count_reg < COUNT_MAX) ? count_reg + 6'd1 : COUNT_MAX;
    assign flags_upd = flags_reg & cls.flag_keep;
    assign acc_upd   = cls.is_hex ? {acc_reg[123:0], cls.nib} : acc_reg;

    // total length picks the layout
    always_comb
    begin
        lay = LAYOUT_PLAIN;
        ok  = 1'b0;
        case (len)
            LEN_PLAIN:
            begin
                lay = LAYOUT_PLAIN;
                ok  = flags_upd[FLAG_PLAIN];
            end
            LEN_HYPHEN:
            begin
                lay = LAYOUT_HYPHEN;
                ok  = flags_upd[FLAG_HYPHEN];
            end
            LEN_CURLY:
            begin
                lay = LAYOUT_CURLY;
                ok  = flags_upd[FLAG_CURLY];
            end
            LEN_URN:
            begin
                lay = LAYOUT_URN;
                ok  = flags_upd[FLAG_URN];
            end
            default:
            begin
                lay = LAYOUT_PLAIN;
                ok  = 1'b0;
            end
        endcase

        res.valid_res = ok;
        res.layout    = ok ? 2'(lay) : 2'(LAYOUT_PLAIN);
        res.uuid_high = ok ? acc_upd[127:64] : 64'd0;
        res.uuid_low  = ok ? acc_upd[63:0] : 64'd0;
    end

    always_comb
    begin
        count_next = count_reg;
        acc_next   = acc_reg;
        flags_next = flags_reg;
        if (accept)
        begin
            if (last_char)
            begin
                count_next = '0;
                acc_next   = '0;
                flags_next = 4'hF;
            end
            else
            begin
                count_next = len;
                acc_next   = acc_upd;
                flags_next = flags_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            acc_reg   <= '0;
            flags_reg <= 4'hF;
        end
        else
        begin
            count_reg <= count_next;
            acc_reg   <= acc_next;
            flags_reg <= flags_next;
        end
    end

    uup_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && last_char),
        .res_in    (res),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_q)
    );

    assign valid_res = res_q.valid_res;
    assign layout    = res_q.layout;
    assign uuid_high = res_q.uuid_high;
    assign uuid_low  = res_q.uuid_low;

endmodule

>>> rtl/uup_checker.sv
// uup_checker: port-level checks for uuid_text_parser_core, bound to the
// top level below. Depends on nothing but the top level's ports.
module uup_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_char,
    input logic        out_valid,
    input logic        out_ready,
    input logic        valid_res,
    input logic [1:0]  layout,
    input logic [63:0] uuid_high,
    input logic [63:0] uuid_low
);

    // a held result does not change until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(layout)
            && $stable(uuid_high) && $stable(uuid_low))
        else $error("result changed while stalled");

    // failed parse reports all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> layout == 2'd0 && uuid_high == 64'd0 && uuid_low == 64'd0)
        else $error("invalid result not zeroed");

    // no input taken while a result is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted over a blocked result");

    // final character yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_char |=> out_valid)
        else $error("missing result after final character");

    // a non-final character never produces a fresh result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_char && (!out_valid || out_ready) |=> !out_valid)
        else $error("result without final character");

endmodule

bind uuid_text_parser_core uup_checker u_uup_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res),
    .layout    (layout),
    .uuid_high (uuid_high),
    .uuid_low  (uuid_low)
);

>>> sim/uuid_text_parser_core_test.sv
// uuid_text_parser_core_test: self-checking testbench for the uuid text parser.
// Depends on rtl/uup_pkg.sv and rtl/uuid_text_parser_core.sv; drives character
// strings in all four layouts, broken and noisy texts, and checks every result.
module uuid_text_parser_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import uup_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_CHARS = 1450;
    localparam logic [71:0] URN_TAG      = "urn:uuid:";

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       drain;
    } char_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'h00;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        valid_res;
    logic [1:0]  layout;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;

    uuid_text_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .layout    (layout),
        .uuid_high (uuid_high),
        .uuid_low  (uuid_low)
    );

    // parser state mirror
    logic [5:0]  prs_count = '0;
    logic [63:0] prs_hi    = '0;
    logic [63:0] prs_lo    = '0;
    logic [3:0]  prs_flags = 4'hF;

    uup_result_t parse_expect[$];
    char_word_t  pending[$];
    logic [7:0]  text_buf[$];

    int          cycle_cnt    = 0;
    int          chars_queued = 0;
    int          chars_taken  = 0;
    int          results_seen = 0;
    int          errors       = 0;
    int          tx_gap       = 0;
    int          rx_gap       = 0;
    logic        in_taken     = 1'b0;
    logic        hold_off     = 1'b0;
    char_word_t  nxt;
    uup_result_t want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        #2 rst_n = 1'b1;
    end

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
        logic hit;
        hit = 1'b1;
        v = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            v = 4'(c - CH_ZERO);
        end
        else if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            v = 4'(c - CH_LO_A + 8'd10);
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            v = 4'(c - CH_UP_A + 8'd10);
        end
        else
        begin
            hit = 1'b0;
        end
        return hit;
    endfunction

    // 8-4-4-4-12 groups: hyphens at 8, 13, 18, 23
    function automatic logic dash_slot_ok(input int p, input logic [7:0] c,
                                          input logic is_hex);
        if (p == 8 || p == 13 || p == 18 || p == 23)
        begin
            return c == CH_HYPHEN;
        end
        return is_hex;
    endfunction

    task automatic predict_char(input logic [7:0] c, input logic fin);
        logic [3:0]  nib;
        logic        is_hex;
        int          pos;
        uup_result_t res;
        is_hex = hex_digit(c, nib);
        pos = prs_count;
        if (is_hex)
        begin
            prs_hi = {prs_hi[59:0], prs_lo[63:60]};
            prs_lo = {prs_lo[59:0], nib};
        end
        if (pos < LEN_PLAIN && !is_hex)
        begin
            prs_flags[FLAG_PLAIN] = 1'b0;
        end
        if (pos < LEN_HYPHEN && !dash_slot_ok(pos, c, is_hex))
        begin
            prs_flags[FLAG_HYPHEN] = 1'b0;
        end
        if (pos == 0)
        begin
            if (c != CH_LBRACE)
            begin
                prs_flags[FLAG_CURLY] = 1'b0;
            end
        end
        else if (pos <= LEN_HYPHEN)
        begin
            if (!dash_slot_ok(pos - 1, c, is_hex))
            begin
                prs_flags[FLAG_CURLY] = 1'b0;
            end
        end
        else if (pos == LEN_CURLY - 1)
        begin
            if (c != CH_RBRACE)
            begin
                prs_flags[FLAG_CURLY] = 1'b0;
            end
        end
        if (pos < PREFIX_LEN)
        begin
            if (c != URN_TAG[71 - 8 * pos -: 8])
            begin
                prs_flags[FLAG_URN] = 1'b0;
            end
        end
        else if (pos < LEN_URN)
        begin
            if (!dash_slot_ok(pos - PREFIX_LEN, c, is_hex))
            begin
                prs_flags[FLAG_URN] = 1'b0;
            end
        end
        prs_count = (pos < COUNT_MAX) ? 6'(pos + 1) : COUNT_MAX;
        if (fin)
        begin
            res = '0;
            case (prs_count)
                LEN_PLAIN:
                begin
                    res.valid_res = prs_flags[FLAG_PLAIN];
                    res.layout = LAYOUT_PLAIN;
                end
                LEN_HYPHEN:
                begin
                    res.valid_res = prs_flags[FLAG_HYPHEN];
                    res.layout = LAYOUT_HYPHEN;
                end
                LEN_CURLY:
                begin
                    res.valid_res = prs_flags[FLAG_CURLY];
                    res.layout = LAYOUT_CURLY;
                end
                LEN_URN:
                begin
                    res.valid_res = prs_flags[FLAG_URN];
                    res.layout = LAYOUT_URN;
                end
                default:
                begin
                    res.valid_res = 1'b0;
                end
            endcase
            if (res.valid_res)
            begin
                res.uuid_high = prs_hi;
                res.uuid_low = prs_lo;
            end
            else
            begin
                res = '0;
            end
            parse_expect.push_back(res);
            prs_count = '0;
            prs_hi = '0;
            prs_lo = '0;
            prs_flags = 4'hF;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_seen, what, got, exp_val);
        errors++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic quiet_window();
        return (cycle_cnt % 1024) < 200;
    endfunction

    // text building
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(s[i]);
        end
    endtask

    // mode 0 lower, 1 upper, 2 mixed case
    task automatic put_hex(input int n, input int mode);
        int  v;
        logic up;
        for (int i = 0; i < n; i++)
        begin
            v = $urandom_range(0, 15);
            up = (mode == 1) || (mode == 2 && $urandom_range(0, 1) == 1);
            if (v < 10)
            begin
                text_buf.push_back(8'(CH_ZERO + v));
            end
            else
            begin
                text_buf.push_back(8'((up ? CH_UP_A : CH_LO_A) + v - 10));
            end
        end
    endtask

    task automatic put_body(input int mode);
        put_hex(8, mode);
        put_str("-");
        put_hex(4, mode);
        put_str("-");
        put_hex(4, mode);
        put_str("-");
        put_hex(4, mode);
        put_str("-");
        put_hex(12, mode);
    endtask

    task automatic build_uuid(input uup_layout_t lay, input int mode);
        case (lay)
            LAYOUT_PLAIN:
            begin
                put_hex(32, mode);
            end
            LAYOUT_HYPHEN:
            begin
                put_body(mode);
            end
            LAYOUT_CURLY:
            begin
                put_str("{");
                put_body(mode);
                put_str("}");
            end
            default:
            begin
                put_str("urn:uuid:");
                put_body(mode);
            end
        endcase
    endtask

    task automatic send_text(input logic drain);
        char_word_t w;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            w.ch = text_buf[i];
            w.fin = (i == text_buf.size() - 1);
            w.drain = drain && (i == 0);
            pending.push_back(w);
        end
        chars_queued += text_buf.size();
        text_buf.delete();
    endtask

    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return (r < 3) ? 8'(CH_ZERO + $urandom_range(0, 9))
                           : 8'(CH_UP_A + $urandom_range(0, 5));
        end
        else if (r < 7)
        begin
            return CH_HYPHEN;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_stimulus();
        int          base;
        int          r;
        int          idx;
        int          n;
        logic        drain;
        uup_layout_t lay;
        // directed: extremes, each layout, malformed forms
        put_str("00000000000000000000000000000000");
        send_text(1'b0);
        put_str("ffffffff-ffff-ffff-ffff-ffffffffffff");
        send_text(1'b0);
        put_str("{FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF}");
        send_text(1'b0);
        put_str("urn:uuid:");
        put_body(2);
        send_text(1'b1);
        put_str("URN:uuid:");
        put_body(0);
        send_text(1'b0);
        put_str("{");
        put_body(1);
        put_str(")");
        send_text(1'b0);
        put_body(0);
        put_str("0");
        send_text(1'b0);
        put_hex(7, 0);
        put_str("-");
        put_hex(5, 0);
        put_str("-");
        put_hex(4, 0);
        put_str("-");
        put_hex(4, 0);
        put_str("-");
        put_hex(12, 0);
        send_text(1'b0);
        put_body(2);
        text_buf[5] = 8'h00;
        send_text(1'b0);
        // characters just outside the hex ranges
        put_str("/:@G`g");
        put_hex(26, 2);
        send_text(1'b0);
        text_buf.push_back(8'hFF);
        send_text(1'b0);
        put_str("x");
        send_text(1'b1);
        // longer than the count can hold
        put_hex(70, 2);
        send_text(1'b0);

        base = chars_queued;
        drain = 1'b1;
        while (chars_queued - base < RANDOM_CHARS)
        begin
            r = $urandom_range(0, 99);
            lay = uup_layout_t'($urandom_range(0, 3));
            if (r < 70)
            begin
                build_uuid(lay, $urandom_range(0, 2));
                if ($urandom_range(0, 99) < 30)
                begin
                    idx = $urandom_range(0, text_buf.size() - 1);
                    case ($urandom_range(0, 3))
                        0: text_buf[idx] = 8'($urandom_range(0, 255));
                        1: text_buf[idx] = noise_char();
                        2: text_buf.delete(idx);
                        default: text_buf.insert(idx, noise_char());
                    endcase
                end
            end
            else if (r < 85)
            begin
                n = $urandom_range(1, 70);
                for (int i = 0; i < n; i++)
                begin
                    text_buf.push_back(noise_char());
                end
            end
            else
            begin
                build_uuid(lay, $urandom_range(0, 2));
                if ($urandom_range(0, 1) == 1)
                begin
                    n = $urandom_range(1, 25);
                    for (int i = 0; i < n; i++)
                    begin
                        text_buf.push_back(noise_char());
                    end
                end
                else
                begin
                    n = $urandom_range(1, 5);
                    repeat (n) void'(text_buf.pop_back());
                end
            end
            send_text(drain);
            drain = ($urandom_range(0, 99) < 4);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (tx_gap > 0)
            begin
                in_valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (pending.size() != 0 && !(pending[0].drain && parse_expect.size() != 0))
            begin
                nxt = pending.pop_front();
                char_code <= nxt.ch;
                last_char <= nxt.fin;
                in_valid <= 1'b1;
                tx_gap <= (hold_off || quiet_window()) ? 0 : pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_window() && $urandom_range(0, 2) == 0)
                begin
                    rx_gap <= pick_gap();
                end
            end
        end
    end

    // long receiver stall so the output word backs up into the input
    initial
    begin
        wait (results_seen >= 8);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // monitor: results are checked before the new word is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (parse_expect.size() == 0)
                begin
                    report_mismatch("unexpected result, valid_res", 64'(valid_res), 64'd0);
                end
                else
                begin
                    want = parse_expect.pop_front();
                    if (valid_res !== want.valid_res)
                    begin
                        report_mismatch("valid_res", 64'(valid_res), 64'(want.valid_res));
                    end
                    if (layout !== want.layout)
                    begin
                        report_mismatch("layout", 64'(layout), 64'(want.layout));
                    end
                    if (uuid_high !== want.uuid_high)
                    begin
                        report_mismatch("uuid_high", uuid_high, want.uuid_high);
                    end
                    if (uuid_low !== want.uuid_low)
                    begin
                        report_mismatch("uuid_low", uuid_low, want.uuid_low);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_char(char_code, last_char);
                chars_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        build_stimulus();
        wait (rst_n);
        while (chars_taken != chars_queued || parse_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/uup_pkg.sv
rtl/uup_char_class.sv
rtl/uup_out_stage.sv
rtl/uuid_text_parser_core.sv
rtl/uup_checker.sv
sim/uuid_text_parser_core_test.sv
